// ----- src/http_get_request_parser_core_assert.svh -----
// ----------------------------------------------------------------------------
// HTTP GET request parser assertion macros
// Concurrent assertion wrappers that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef HTTP_GET_REQUEST_PARSER_CORE_ASSERT_SVH
`define HTTP_GET_REQUEST_PARSER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define HGRP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define HGRP_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HGRP_ASSERT(lbl, prop, msg)
`define HGRP_ASSERT_RST(lbl, prop, msg)
`endif

`endif

// ----- src/hgrp_pkg.sv -----
// ----------------------------------------------------------------------------
// HTTP GET request parser package
// Shared types, character constants and the parser state record.
// ----------------------------------------------------------------------------
`default_nettype none

package hgrp_pkg;

  typedef enum logic [1:0] {
    PH_LINE,
    PH_HEADERS,
    PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    RK_PATH,
    RK_ACCEPT,
    RK_BAD,
    RK_EARLY
  } rkind_t;

  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [2:0] METHOD_LEN  = 3'd4;
  localparam logic [3:0] VERSION_LEN = 4'd10;
  localparam logic [3:0] VERSION_SAT = 4'd11;
  localparam logic [1:0] SPACE_SAT   = 2'd3;
  localparam logic [1:0] HDR_SAT     = 2'd3;

  localparam logic [3:0][7:0] METHOD_TEXT = {8'h20, 8'h54, 8'h45, 8'h47};

  typedef struct packed {
    phase_t     phase;
    logic [2:0] method_position;
    logic [1:0] space_count;
    logic [3:0] version_byte_count;
    logic       line_malformed;
    logic       previous_was_cr;
    logic [1:0] header_line_length;
  } pstate_t;

  typedef struct packed {
    logic       valid;
    rkind_t     kind;
    logic [7:0] byte_val;
  } presult_t;

  localparam pstate_t PSTATE_RESET = '{
    phase:              PH_LINE,
    method_position:    3'd0,
    space_count:        2'd0,
    version_byte_count: 4'd0,
    line_malformed:     1'b0,
    previous_was_cr:    1'b0,
    header_line_length: 2'd0
  };

endpackage

`default_nettype wire

// ----- src/http_get_request_parser_core.sv -----
// An accepted byte is held in the input register; its result word then goes to the result register.
// Throughput: one byte per cycle unless the result register stalls; the state update for
// each byte is a single pass of logic. A stalled result register holds the input register,
// which then stalls the input side. Reset (rst, synchronous, active high) empties both
// registers and returns the parser to the start of a request line.
// ----------------------------------------------------------------------------
// HTTP GET request parser core
// Parses a connection's byte stream, emitting path bytes and the request verdict.
// ----------------------------------------------------------------------------
`default_nettype none

`include "http_get_request_parser_core_assert.svh"

module http_get_request_parser_core import hgrp_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       req_valid,
  output logic            req_ready,
  input  wire logic       kind,
  input  wire logic [7:0] data_byte,
  output logic            res_valid,
  input  wire logic       res_ready,
  output logic [1:0]      result_kind,
  output logic [7:0]      path_byte
);

  logic       inq_valid;
  logic       inq_kind;
  logic [7:0] inq_byte;
  logic       advance;
  pstate_t    st;
  pstate_t    st_next;
  presult_t   step_res;
  logic       res_valid_next;
  rkind_t     res_kind;
  logic [7:0] res_byte;

  hgrp_step u_step (
    .cur       (st),
    .kind      (inq_kind),
    .data_byte (inq_byte),
    .nxt       (st_next),
    .res       (step_res)
  );

  assign advance   = inq_valid && (!res_valid || res_ready);
  assign req_ready = !inq_valid || advance;

  always_comb begin
    if (advance) begin
      res_valid_next = step_res.valid;
    end else begin
      res_valid_next = res_valid && !res_ready;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inq_valid <= 1'b0;
      res_valid <= 1'b0;
      st        <= PSTATE_RESET;
    end else begin
      if (req_ready) begin
        inq_valid <= req_valid;
      end
      res_valid <= res_valid_next;
      if (advance) begin
        st <= st_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      inq_kind <= kind;
      inq_byte <= data_byte;
    end
    if (advance && step_res.valid) begin
      res_kind <= step_res.kind;
      res_byte <= step_res.byte_val;
    end
  end

  assign result_kind = res_kind;
  assign path_byte   = res_byte;

  `HGRP_ASSERT_RST(a_reset_clears, rst |=> !res_valid && !inq_valid && st.phase == PH_LINE, "reset did not clear the parser")
  `HGRP_ASSERT(a_zero_unless_path, res_valid && result_kind != RK_PATH |-> path_byte == 8'd0, "non-path result carries a byte")
  `HGRP_ASSERT(a_headers_after_good, st.phase == PH_HEADERS |-> st.space_count == 2'd2 && st.method_position == METHOD_LEN, "header phase without a valid request line")
  `HGRP_ASSERT(a_held_word_kept, inq_valid && !advance |=> inq_valid && $stable(inq_kind) && $stable(inq_byte), "pending word lost")

endmodule

`default_nettype wire

// ----- src/hgrp_step.sv -----
// ----------------------------------------------------------------------------
// HTTP GET request parser step logic
// Computes the next parser state and the optional result for one word.
// ----------------------------------------------------------------------------
`default_nettype none

module hgrp_step import hgrp_pkg::*; (
  input  wire pstate_t  cur,
  input  wire logic     kind,
  input  wire logic [7:0] data_byte,
  output pstate_t       nxt,
  output presult_t      res
);

  logic       ended;
  logic       good;
  logic       mal;
  logic [2:0] mp;
  logic [1:0] sc;
  logic [3:0] vc;

  always_comb begin
    nxt   = cur;
    res   = '{valid: 1'b0, kind: RK_PATH, byte_val: 8'd0};
    ended = cur.previous_was_cr && (data_byte == CH_LF);
    mal   = cur.line_malformed;
    mp    = cur.method_position;
    sc    = cur.space_count;
    vc    = cur.version_byte_count;
    good  = 1'b0;
    if (kind) begin
      nxt = PSTATE_RESET;
      if (cur.phase != PH_DONE) begin
        res = '{valid: 1'b1, kind: RK_EARLY, byte_val: 8'd0};
      end
    end else begin
      unique case (cur.phase)
        PH_LINE: begin
          if (cur.method_position < METHOD_LEN) begin
            if (data_byte != METHOD_TEXT[cur.method_position[1:0]]) begin
              mal = 1'b1;
            end
            mp = cur.method_position + 3'd1;
          end
          if (data_byte == CH_SPACE) begin
            if (cur.space_count < SPACE_SAT) begin
              sc = cur.space_count + 2'd1;
            end
            if (sc == SPACE_SAT) begin
              mal = 1'b1;
            end
          end else if (cur.space_count == 2'd1) begin
            if (!ended) begin
              res = '{valid: 1'b1, kind: RK_PATH, byte_val: data_byte};
            end
          end else if (cur.space_count == 2'd2) begin
            if (cur.version_byte_count < VERSION_SAT) begin
              vc = cur.version_byte_count + 4'd1;
            end
          end
          nxt.method_position    = mp;
          nxt.space_count        = sc;
          nxt.version_byte_count = vc;
          nxt.line_malformed     = mal;
          if (ended) begin
            good = !mal && (mp == METHOD_LEN) && (sc == 2'd2) && (vc == VERSION_LEN);
            nxt.previous_was_cr = 1'b0;
            if (!good) begin
              nxt.phase = PH_DONE;
              res = '{valid: 1'b1, kind: RK_BAD, byte_val: 8'd0};
            end else begin
              nxt.phase = PH_HEADERS;
              nxt.header_line_length = 2'd0;
            end
          end else begin
            nxt.previous_was_cr = (data_byte == CH_CR);
          end
        end
        PH_HEADERS: begin
          if (ended) begin
            nxt.previous_was_cr = 1'b0;
            if (cur.header_line_length == 2'd1) begin
              nxt.phase = PH_DONE;
              res = '{valid: 1'b1, kind: RK_ACCEPT, byte_val: 8'd0};
            end else begin
              nxt.header_line_length = 2'd0;
            end
          end else begin
            if (cur.header_line_length < HDR_SAT) begin
              nxt.header_line_length = cur.header_line_length + 2'd1;
            end
            nxt.previous_was_cr = (data_byte == CH_CR);
          end
        end
        PH_DONE: begin
          nxt = cur;
        end
        default: begin
          nxt = cur;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
